>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sha_pkg.sv
// Types, constants and state encodings of the SHA-256 byte hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

    typedef logic [7:0][31:0] sha_words_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } sha_state_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_LOAD,
        ENG_RUN,
        ENG_DONE
    } sha_eng_state_t;

    typedef struct packed {
        logic       done;
        logic [3:0] rd_addr;
    } sha_eng_stat_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [2:0] LAST_WORD = 3'd7;
    localparam logic [5:0] LAST_BYTE = 6'd63;

    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/sha_stream_if.sv
// Request channels of the hasher: message bytes in, digest words out.
`timescale 1ns / 1ps
`default_nettype none

interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_final;

    modport source (output valid, data_byte, byte_present, is_final, input ready);
    modport sink (input valid, data_byte, byte_present, is_final, output ready);
endinterface

interface sha_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> src/sha_engine.sv
// SHA-256 compression engine: one round per cycle over the block memory.
`timescale 1ns / 1ps
`default_nettype none

module sha_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire sha_pkg::sha_words_t chain_in,
    input  wire logic [31:0]        rdata,
    output sha_pkg::sha_eng_stat_t  stat,
    output sha_pkg::sha_words_t     sum_out
);

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    sha_pkg::sha_eng_state_t state_reg, state_next;
    logic [5:0]          cnt_reg;
    logic [31:0]         pre_reg;
    sha_pkg::sha_words_t v_reg;
    logic [31:0]         sw_reg [16];

    logic [31:0] w_next, pre_next, t1, t2, s0, s1, ch, mj, sg0, sg1;

    always_comb
    begin
        // sw_reg[15] holds W of the current round
        sg0    = ror(sw_reg[1], 7) ^ ror(sw_reg[1], 18) ^ (sw_reg[1] >> 3);
        sg1    = ror(sw_reg[14], 17) ^ ror(sw_reg[14], 19) ^ (sw_reg[14] >> 10);
        w_next = (cnt_reg <= 6'd14) ? rdata : (sg1 + sw_reg[9] + sg0 + sw_reg[0]);
        // h of the next round is g of this one
        pre_next = v_reg[6] + sha_pkg::k_const(6'(cnt_reg + 6'd1)) + w_next;
        s1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = pre_reg + s1 + ch;
        s0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;

        state_next   = state_reg;
        stat.done    = 1'b0;
        stat.rd_addr = 4'd0;
        case (state_reg)
            sha_pkg::ENG_IDLE:
            begin
                if (start)
                begin
                    state_next = sha_pkg::ENG_LOAD;
                end
            end
            sha_pkg::ENG_LOAD:
            begin
                stat.rd_addr = 4'd1;
                state_next   = sha_pkg::ENG_RUN;
            end
            sha_pkg::ENG_RUN:
            begin
                stat.rd_addr = cnt_reg[3:0] + 4'd2;
                if (cnt_reg == 6'd63)
                begin
                    state_next = sha_pkg::ENG_DONE;
                end
            end
            sha_pkg::ENG_DONE:
            begin
                stat.done  = 1'b1;
                state_next = sha_pkg::ENG_IDLE;
            end
            default:
            begin
                state_next = sha_pkg::ENG_IDLE;
            end
        endcase

        for (int i = 0; i < 8; i++)
        begin
            sum_out[i] = chain_in[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ENG_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sha_pkg::ENG_RUN)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            else
            begin
                cnt_reg <= 6'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sha_pkg::ENG_LOAD)
        begin
            v_reg      <= chain_in;
            pre_reg    <= chain_in[7] + sha_pkg::k_const(6'd0) + rdata;
            sw_reg[15] <= rdata;
        end
        else if (state_reg == sha_pkg::ENG_RUN)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sw_reg[i] <= sw_reg[i + 1];
            end
            sw_reg[15] <= w_next;
            pre_reg    <= pre_next;
            v_reg[7]   <= v_reg[6];
            v_reg[6]   <= v_reg[5];
            v_reg[5]   <= v_reg[4];
            v_reg[4]   <= v_reg[3] + t1;
            v_reg[3]   <= v_reg[2];
            v_reg[2]   <= v_reg[1];
            v_reg[1]   <= v_reg[0];
            v_reg[0]   <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

>>> src/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte-stream hasher.
//
//   channel  dir  payload                                  handshake
//   msg      in   data_byte, byte_present, is_final        valid/ready
//   digest   out  digest_word, word_index, last_word       valid/ready
//
// A byte is taken while the block is idle; the 64th byte of a block starts
// the compression, one round per cycle with the message words read from the
// block memory. A final request writes the padding one byte per cycle (up to
// 64 a block, 72 over two blocks), runs one or two compressions, then
// presents eight digest words.
// msg.ready is low from a final request or a full block until the work ends.
// Reset restores the initial chaining words; the block memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_top (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_byte_if.sink  msg,
    sha_word_if.source digest
);

    sha_pkg::sha_state_t    state_reg, state_next;
    logic [5:0]             fill_reg, fill_next;
    logic [63:0]            bits_reg, bits_next;
    logic                   final_reg, final_next;
    logic                   first_reg, first_next;
    logic                   extra_reg, extra_next;
    logic                   emit_reg, emit_next;
    logic [2:0]             idx_reg, idx_next;
    sha_pkg::sha_words_t    chain_reg, chain_next;

    logic [31:0]            blk_mem [16];
    logic [31:0]            rdata_reg;
    logic                   wr_en;
    logic [7:0]             wr_byte;
    logic                   go_extra;
    logic                   eng_start;
    sha_pkg::sha_eng_stat_t eng_stat;
    sha_pkg::sha_words_t    eng_sum;

    sha_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .chain_in (chain_reg),
        .rdata    (rdata_reg),
        .stat     (eng_stat),
        .sum_out  (eng_sum)
    );

    assign msg.ready          = (state_reg == sha_pkg::ST_IDLE);
    assign digest.valid       = (state_reg == sha_pkg::ST_EMIT);
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == sha_pkg::LAST_WORD);
    assign eng_start          = (state_reg == sha_pkg::ST_COMP);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        final_next = final_reg;
        first_next = first_reg;
        extra_next = extra_reg;
        emit_next  = emit_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        wr_en      = 1'b0;
        wr_byte    = msg.data_byte;
        go_extra   = first_reg ? (fill_reg[5:3] == 3'b111) : extra_reg;

        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (msg.valid)
                begin
                    final_next = msg.is_final;
                    first_next = 1'b1;
                    if (msg.byte_present)
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == sha_pkg::LAST_BYTE)
                        begin
                            state_next = sha_pkg::ST_COMP;
                        end
                        else if (msg.is_final)
                        begin
                            state_next = sha_pkg::ST_PAD;
                        end
                    end
                    else if (msg.is_final)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                wr_en = 1'b1;
                if (first_reg)
                begin
                    wr_byte = sha_pkg::PAD_MARK;
                end
                else if (extra_reg || (fill_reg[5:3] != 3'b111))
                begin
                    wr_byte = 8'h00;
                end
                else
                begin
                    // length trailer, most significant byte first
                    wr_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                first_next = 1'b0;
                extra_next = go_extra;
                fill_next  = fill_reg + 6'd1;
                if (fill_reg == sha_pkg::LAST_BYTE)
                begin
                    extra_next = 1'b0;
                    emit_next  = !go_extra;
                    state_next = sha_pkg::ST_COMP;
                end
            end
            sha_pkg::ST_COMP:
            begin
                if (eng_stat.done)
                begin
                    chain_next = eng_sum;
                    if (emit_reg)
                    begin
                        state_next = sha_pkg::ST_EMIT;
                    end
                    else if (final_reg)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::LAST_WORD)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_next[i] = sha_pkg::iv_const(3'(i));
                        end
                        fill_next  = 6'd0;
                        bits_next  = 64'd0;
                        final_next = 1'b0;
                        emit_next  = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            final_reg <= 1'b0;
            first_reg <= 1'b0;
            extra_reg <= 1'b0;
            emit_reg  <= 1'b0;
            idx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::iv_const(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            final_reg <= final_next;
            first_reg <= first_next;
            extra_reg <= extra_next;
            emit_reg  <= emit_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    // block memory: byte writes, big-endian within each word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
        rdata_reg <= blk_mem[eng_stat.rd_addr];
    end

endmodule

`default_nettype wire

>>> src/sha_chk.sv
// Port-level checker for the hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sha_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] word_index,
    input wire logic       last_word
);

    `CHK_SAME(a_last_flag, out_valid, last_word == (word_index == 3'd7), "last_word misplaced")
    `CHK_SAME(a_no_take_in_emit, out_valid, !in_ready, "byte taken while digest pending")
    `CHK_NEXT(a_word_order, out_valid && out_ready && !last_word, out_valid && (word_index == 3'($past(word_index) + 3'd1)), "digest word order broken")
    `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(word_index), "stalled word dropped")

endmodule

bind sha256_byte_stream_hasher_top sha_chk u_sha_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (msg.ready),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .word_index (digest.word_index),
    .last_word  (digest.last_word)
);

`default_nettype wire

>>> tb/sha256_byte_stream_hasher_top_test.sv
// Testbench for the SHA-256 byte-stream hasher: directed table, padding boundaries, then random messages.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_top_test;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_final;
    } msg_req_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_req_t;

    typedef struct {
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        is_final;
        logic        typed;
        logic [31:0] word0;
    } stim_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 64;

    logic clk;
    logic rst_n;

    sha_byte_if msg ();
    sha_word_if digest ();

    sha256_byte_stream_hasher_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg.sink),
        .digest(digest.source)
    );

    // Model state
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;

    digest_req_t digest_q[$];
    logic [31:0] typed_word0_q[$];
    int          fails;
    int          idle_cycles;
    bit          send_done;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input int t);
        logic [31:0] tbl [64];
        tbl = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return tbl[t];
    endfunction

    function automatic logic [31:0] start_word(input int i);
        logic [31:0] tbl [8];
        tbl = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return tbl[i];
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endtask

    task automatic hash_init();
        for (int i = 0; i < 8; i++)
            chain[i] = start_word(i);
        fill = 0;
        msg_bits = '0;
    endtask

    // Advance the predicted hash state by one accepted request.
    task automatic hash_absorb(input msg_req_t r);
        digest_req_t d;
        if (r.byte_present) begin
            blk[fill] = r.data_byte;
            fill++;
            msg_bits += 64'd8;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (r.is_final) begin
            blk[fill] = sha_pkg::PAD_MARK;
            fill++;
            if (fill > 56) begin
                while (fill < 64) blk[fill++] = 8'h00;
                compress();
                fill = 0;
            end
            while (fill < 56) blk[fill++] = 8'h00;
            for (int i = 0; i < 8; i++)
                blk[56+i] = msg_bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                d.digest_word = chain[i];
                d.word_index = 3'(i);
                d.last_word = (3'(i) == sha_pkg::LAST_WORD);
                digest_q.push_back(d);
            end
            hash_init();
        end
    endtask

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send(input msg_req_t r);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        msg.valid = 1'b1;
        msg.data_byte = r.data_byte;
        msg.byte_present = r.byte_present;
        msg.is_final = r.is_final;
        do @(posedge clk); while (!msg.ready);
        hash_absorb(r);
        @(negedge clk);
        msg.valid = 1'b0;
        msg.data_byte = 8'($urandom);
    endtask

    task automatic send_bytes(input int n, input bit fin);
        msg_req_t r;
        for (int i = 0; i < n; i++) begin
            r.data_byte = 8'($urandom);
            r.byte_present = 1'b1;
            r.is_final = fin && (i == n - 1);
            send(r);
        end
    endtask

    // Accept digest words with random stalls.
    initial begin
        digest_req_t exp_w;
        int stall;
        digest.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                digest.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            digest.ready <= 1'b1;
            do @(posedge clk); while (!digest.valid);
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, digest.digest_word);
                fails++;
            end else begin
                exp_w = digest_q.pop_front();
                if (exp_w.word_index == 3'd0 && typed_word0_q.size() > 0 &&
                    digest.digest_word !== typed_word0_q[0]) begin
                    $display("%0t: known digest word0 expected %h actual %h", $time,
                             typed_word0_q[0], digest.digest_word);
                    fails++;
                end
                if (exp_w.word_index == 3'd0 && typed_word0_q.size() > 0)
                    void'(typed_word0_q.pop_front());
                if (digest.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, digest.digest_word);
                    fails++;
                end
                if (digest.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, digest.word_index);
                    fails++;
                end
                if (digest.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             exp_w.last_word, digest.last_word);
                    fails++;
                end
            end
        end
    end

    // Count cycles with no request moving on either side.
    always @(posedge clk) begin
        if ((msg.valid && msg.ready) || (digest.valid && digest.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        msg_req_t r;
        int n;
        fails = 0;
        idle_cycles = 0;
        send_done = 1'b0;
        msg.valid = 1'b0;
        msg.data_byte = 8'h00;
        msg.byte_present = 1'b0;
        msg.is_final = 1'b0;
        rst_n = 1'b0;
        hash_init();
        // empty message, "abc", idle item, extremes of the byte field
        rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
        rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
        rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
        rows.push_back('{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0});
        rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf});
        rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'h0});
        rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 32'h0});
        rows.push_back('{8'hff, 1'b0, 1'b1, 1'b0, 32'h0});
        rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 32'h0});
        rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 32'h0});
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            if (row.typed) typed_word0_q.push_back(row.word0);
            r.data_byte = row.data_byte;
            r.byte_present = row.byte_present;
            r.is_final = row.is_final;
            send(r);
        end

        // Padding boundaries: 55, 56, 63 and 64 byte messages.
        send_bytes(55, 1'b1);
        send_bytes(56, 1'b1);
        wait (digest_q.size() == 0);
        @(negedge clk);
        send_bytes(63, 1'b1);
        send_bytes(64, 1'b1);

        // Random messages, mostly short, with noise items mixed in.
        n = 0;
        while (n < NUM_RANDOM) begin
            if ($urandom_range(0, 9) == 0) begin
                r.data_byte = 8'($urandom);
                r.byte_present = 1'b0;
                r.is_final = 1'($urandom_range(0, 1));
                send(r);
                n++;
            end else begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70)
                                                  : $urandom_range(0, 20);
                if (len == 0) begin
                    r.data_byte = 8'($urandom);
                    r.byte_present = 1'b0;
                    r.is_final = 1'b1;
                    send(r);
                    n++;
                end else begin
                    send_bytes(len, $urandom_range(0, 4) != 0);
                    n += len;
                end
            end
        end
        // Close any open message.
        r.data_byte = 8'h00;
        r.byte_present = 1'b0;
        r.is_final = 1'b1;
        send(r);

        wait (digest_q.size() == 0);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
